/* rtl/core/alcr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alcr_pkg: shared types and constants of the aging-life replacement directory
// Holds the request and result structs, operation and status codes, the
// register indexes and the controller state encoding.
// ----------------------------------------------------------------------------
package alcr_pkg;

  localparam int ENTRIES_DEF = 16;

  typedef enum logic [1:0] {
    OP_OPEN  = 2'd0,
    OP_PIN   = 2'd1,
    OP_UNPIN = 2'd2,
    OP_INVAL = 2'd3
  } op_t;

  localparam logic [2:0] ST_HIT     = 3'd0;
  localparam logic [2:0] ST_FILLED  = 3'd1;
  localparam logic [2:0] ST_NO_SLOT = 3'd2;
  localparam logic [2:0] ST_FAILED  = 3'd3;
  localparam logic [2:0] ST_DONE    = 3'd4;

  localparam logic [2:0] REG_ENTRY_COUNT = 3'd0;
  localparam logic [2:0] REG_LIFE_LIMIT  = 3'd1;
  localparam logic [2:0] REG_RET_SLOTS   = 3'd2;
  localparam logic [2:0] REG_RET_BYTES   = 3'd3;
  localparam logic [2:0] REG_RET_PIXELS  = 3'd4;
  localparam logic [2:0] REG_RET_OPEN    = 3'd5;

  localparam logic signed [31:0] LIFE_FLOOR = 32'sh8000_0000;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [31:0]        source_key;
    logic [31:0]        pixel_color;
    logic signed [31:0] frame_number;
    logic               all_entries;
    logic [3:0]         slot_index;
    logic               open_ok;
    logic [15:0]        open_time;
    logic [10:0]        image_width;
    logic [10:0]        image_height;
  } req_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [3:0]         slot;
    logic [15:0]        closed_mask;
    logic               now_retained;
    logic signed [31:0] slot_life;
  } res_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_AGE,
    S_MATCH,
    S_VIC1,
    S_VIC2,
    S_FILL,
    S_RB_SCAN,
    S_RB_ACT,
    S_PIN,
    S_INVAL,
    S_DONE
  } state_t;

  // Commands from controller to datapath.
  typedef struct packed {
    logic load;       // capture request, clear scan state
    logic scan_clr;   // end of a scan pass; not used by the datapath
    logic age;        // age slot at scan index
    logic match;      // compare slot at scan index
    logic vic1;       // first victim pass step
    logic vic2;       // second victim pass step
    logic fill;       // fill victim slot
    logic rb_scan;    // rebalance accumulate step
    logic rb_act;     // rebalance demotion
    logic pin;        // pin or unpin
    logic inval;      // invalidate slot at scan index
    logic emit;       // output result
  } cmd_t;

  typedef struct packed {
    logic scan_last;  // scan index is last active slot
    logic empty;      // no active slots
    logic hit;        // match found
    logic vic_found;  // first-pass victim found
    logic vic_empty;  // empty victim found, stop scanning
    logic vic_any;    // victim found and the open succeeded, so rebalance follows
    logic rb_ok;      // lane within budget
    logic rb_stop;    // demotion target not retained
  } sts_t;

endpackage

/* rtl/core/alcr_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alcr_ctrl: sequencing controller
// Walks each request through its slot scans and issues datapath commands.
// ----------------------------------------------------------------------------
module alcr_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  alcr_pkg::op_t   opcode,
  input  alcr_pkg::sts_t  sts,
  output logic            busy,
  output alcr_pkg::cmd_t  cmd
);
  import alcr_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          case (opcode)
            OP_OPEN:  state_next = S_AGE;
            OP_INVAL: state_next = S_INVAL;
            default:  state_next = S_PIN;
          endcase
        end
      end
      S_AGE: begin
        if (sts.empty) state_next = S_DONE;
        else if (sts.scan_last) state_next = S_MATCH;
      end
      S_MATCH: begin
        if (sts.hit) state_next = S_DONE;
        else if (sts.scan_last) state_next = S_VIC1;
      end
      S_VIC1: begin
        if (sts.vic_empty) state_next = S_FILL;
        else if (sts.scan_last) state_next = sts.vic_found ? S_FILL : S_VIC2;
      end
      S_VIC2: if (sts.scan_last) state_next = S_FILL;
      S_FILL: state_next = sts.vic_any ? S_RB_SCAN : S_DONE;
      S_RB_SCAN: if (sts.scan_last) state_next = S_RB_ACT;
      S_RB_ACT: begin
        if (sts.rb_ok || sts.rb_stop) state_next = S_DONE;
        else state_next = S_RB_SCAN;
      end
      S_PIN: state_next = S_DONE;
      S_INVAL: if (sts.scan_last || sts.empty) state_next = S_DONE;
      S_DONE: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    busy = (state != S_IDLE);
    case (state)
      S_IDLE: cmd.load = start;
      S_AGE: begin
        cmd.age = 1'b1;
        cmd.scan_clr = sts.scan_last;
      end
      S_MATCH: begin
        cmd.match = 1'b1;
        cmd.scan_clr = sts.scan_last;
      end
      S_VIC1: begin
        cmd.vic1 = 1'b1;
        cmd.scan_clr = sts.scan_last;
      end
      S_VIC2: begin
        cmd.vic2 = 1'b1;
        cmd.scan_clr = sts.scan_last;
      end
      S_FILL: cmd.fill = 1'b1;
      S_RB_SCAN: cmd.rb_scan = 1'b1;
      S_RB_ACT: begin
        cmd.rb_act = 1'b1;
        cmd.scan_clr = 1'b1;
      end
      S_PIN: cmd.pin = 1'b1;
      S_INVAL: cmd.inval = 1'b1;
      S_DONE: cmd.emit = 1'b1;
      default: cmd = '0;
    endcase
  end

endmodule

/* rtl/core/alcr_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alcr_dp: slot store and scan datapath
// Holds the slot registers, configuration, the scan index and accumulators,
// and builds the result.
// ----------------------------------------------------------------------------
module alcr_dp #(
  parameter int ENTRIES = alcr_pkg::ENTRIES_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  alcr_pkg::req_t  req,
  input  alcr_pkg::cmd_t  cmd,
  input  logic            cfg_valid,
  input  logic [2:0]      cfg_index,
  input  logic [31:0]     cfg_data,
  output alcr_pkg::sts_t  sts,
  output logic            done,
  output alcr_pkg::res_t  res
);
  import alcr_pkg::*;

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);
  localparam int SW = (IW > 4) ? IW : 4;

  logic [4:0]  entry_count;
  logic [15:0] life_limit;
  logic [4:0]  retained_slots;
  logic [31:0] retained_max_bytes;
  logic [22:0] retained_min_pixels;
  logic [15:0] retained_min_open;

  logic               s_valid [ENTRIES];
  logic [31:0]        s_key   [ENTRIES];
  logic [31:0]        s_color [ENTRIES];
  logic signed [31:0] s_frame [ENTRIES];
  logic signed [31:0] s_life  [ENTRIES];
  logic [15:0]        s_cost  [ENTRIES];
  logic [10:0]        s_w     [ENTRIES];
  logic [10:0]        s_h     [ENTRIES];
  logic               s_ret   [ENTRIES];
  logic [7:0]         s_pins  [ENTRIES];
  logic               s_pend  [ENTRIES];

  req_t         r;
  logic [IW-1:0] idx;
  logic [IW-1:0] best;
  logic          best_ok;
  logic [CW-1:0] rb_count;
  logic [33:0]   rb_bytes;
  logic [IW-1:0] weak_idx;
  logic          weak_ok;
  logic [IW-1:0] vic;
  logic [2:0]    o_status;
  logic [SW-1:0] o_slot;
  logic [ENTRIES-1:0] closed;
  logic          o_ret;
  logic signed [31:0] o_life;

  logic [CW-1:0] n;
  logic [5:0]    n_wide;
  assign n_wide = (32'(entry_count) > ENTRIES) ? 6'(ENTRIES) : {1'b0, entry_count};
  assign n = CW'(n_wide);

  logic [CW-1:0] idx_ext;
  assign idx_ext = CW'(idx);
  assign sts.scan_last = (idx_ext + 1'b1) >= n;
  assign sts.empty = (n == '0);

  // Per-slot views at the scan index.
  logic               c_valid, c_ret;
  logic [31:0]        c_key, c_color;
  logic signed [31:0] c_frame, c_life;
  logic [15:0]        c_cost;
  logic [10:0]        c_w, c_h;
  logic [7:0]         c_pins;
  assign c_valid = s_valid[idx];
  assign c_ret   = s_ret[idx];
  assign c_key   = s_key[idx];
  assign c_color = s_color[idx];
  assign c_frame = s_frame[idx];
  assign c_life  = s_life[idx];
  assign c_cost  = s_cost[idx];
  assign c_w     = s_w[idx];
  assign c_h     = s_h[idx];
  assign c_pins  = s_pins[idx];

  logic is_match;
  assign is_match = c_valid && c_key == r.source_key && c_color == r.pixel_color
                    && c_frame == r.frame_number;
  assign sts.hit = cmd.match && is_match;

  logic signed [32:0] hit_sum;
  logic signed [31:0] hit_life;
  assign hit_sum = 33'(c_life) + 33'($signed({1'b0, c_cost}));
  assign hit_life = (hit_sum > $signed({17'b0, life_limit})) ?
                    32'($signed({16'b0, life_limit})) : hit_sum[31:0];

  logic v1_cand, v1_better, v2_cand;
  assign v1_cand = (c_pins == 8'd0) && c_valid && !c_ret;
  assign v1_better = !best_ok || (c_life < s_life[best]);
  assign v2_cand = (c_pins == 8'd0);
  assign sts.vic_empty = cmd.vic1 && (c_pins == 8'd0) && !c_valid;
  assign sts.vic_found = best_ok || (v1_cand && v1_better);
  assign sts.vic_any = best_ok && r.open_ok;

  // Fill values.
  logic [15:0] f_cost;
  logic [21:0] f_pix;
  logic        f_ret;
  logic signed [31:0] f_life;
  assign f_cost = (r.open_time == 16'd0) ? 16'd1 : r.open_time;
  assign f_pix  = r.image_width * r.image_height;
  assign f_ret  = (f_cost >= retained_min_open) && ({1'b0, f_pix} >= retained_min_pixels);
  assign f_life = (f_cost > life_limit) ? 32'($signed({16'b0, life_limit}))
                                        : 32'($signed({16'b0, f_cost}));

  // Rebalance step operands.
  logic [21:0] c_pix;
  assign c_pix = c_w * c_h;
  logic [IW-1:0] rb_tgt;
  assign rb_tgt = weak_ok ? weak_idx : vic;
  assign sts.rb_ok = (32'(rb_count) <= 32'(retained_slots))
                     && (rb_bytes <= {2'b0, retained_max_bytes});
  assign sts.rb_stop = !s_ret[rb_tgt];

  logic [7:0] pin_cur;
  logic [IW-1:0] pidx;
  logic          pin_in;
  assign pidx = IW'(r.slot_index);
  assign pin_in = ({1'b0, r.slot_index} < 5'(n_wide)) && (32'(r.slot_index) < ENTRIES);
  assign pin_cur = s_pins[pidx];

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= 5'd16;
      life_limit <= 16'd1000;
      retained_slots <= 5'd6;
      retained_max_bytes <= 32'd12582912;
      retained_min_pixels <= 23'd200000;
      retained_min_open <= 16'd8;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_ENTRY_COUNT: entry_count <= cfg_data[4:0];
        REG_LIFE_LIMIT:  life_limit <= cfg_data[15:0];
        REG_RET_SLOTS:   retained_slots <= cfg_data[4:0];
        REG_RET_BYTES:   retained_max_bytes <= cfg_data;
        REG_RET_PIXELS:  retained_min_pixels <= cfg_data[22:0];
        REG_RET_OPEN:    retained_min_open <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ENTRIES; i++) begin
        s_valid[i] <= 1'b0; s_key[i] <= '0; s_color[i] <= '0; s_frame[i] <= '0;
        s_life[i] <= '0; s_cost[i] <= '0; s_w[i] <= '0; s_h[i] <= '0;
        s_ret[i] <= 1'b0; s_pins[i] <= '0; s_pend[i] <= 1'b0;
      end
      idx <= '0; best <= '0; best_ok <= 1'b0;
      rb_count <= '0; rb_bytes <= '0; weak_idx <= '0; weak_ok <= 1'b0; vic <= '0;
      o_status <= ST_DONE; o_slot <= '0; closed <= '0; o_ret <= 1'b0; o_life <= '0;
      done <= 1'b0;
    end else begin
      done <= cmd.emit;
      if (cmd.load) begin
        r <= req;
        idx <= '0; best_ok <= 1'b0;
        rb_count <= '0; rb_bytes <= '0; weak_ok <= 1'b0;
        o_status <= (req.opcode == OP_OPEN) ? ST_NO_SLOT : ST_DONE;
        o_slot <= '0; closed <= '0; o_ret <= 1'b0; o_life <= '0;
      end
      if (cmd.age || cmd.match || cmd.vic1 || cmd.vic2 || cmd.rb_scan || cmd.inval)
        idx <= sts.scan_last ? '0 : idx + 1'b1;
      if (cmd.age && !sts.empty && c_life > (LIFE_FLOOR + 32'sd1))
        s_life[idx] <= c_life - 32'sd1;
      if (cmd.match && is_match) begin
        s_life[idx] <= hit_life;
        o_status <= ST_HIT; o_slot <= SW'(idx); o_ret <= c_ret; o_life <= hit_life;
      end
      if (cmd.vic1) begin
        if (sts.vic_empty) begin
          best <= idx; best_ok <= 1'b1;
        end else if (v1_cand && v1_better) begin
          best <= idx; best_ok <= 1'b1;
        end
      end
      if (cmd.vic2 && v2_cand && (!best_ok || c_life < s_life[best])) begin
        best <= idx; best_ok <= 1'b1;
      end
      if (cmd.fill) begin
        // An empty victim can stop the scan early, so rewind for the rebalance.
        idx <= '0;
        if (best_ok) begin
          vic <= best;
          o_slot <= SW'(best);
          if (s_valid[best]) closed[best] <= 1'b1;
          s_pins[best] <= '0; s_pend[best] <= 1'b0;
          if (!r.open_ok) begin
            s_valid[best] <= 1'b0; s_key[best] <= '0; s_color[best] <= '0;
            s_frame[best] <= '0; s_cost[best] <= '0; s_w[best] <= '0; s_h[best] <= '0;
            s_ret[best] <= 1'b0; s_life[best] <= LIFE_FLOOR;
            o_status <= ST_FAILED; o_life <= LIFE_FLOOR;
          end else begin
            s_valid[best] <= 1'b1; s_key[best] <= r.source_key;
            s_color[best] <= r.pixel_color; s_frame[best] <= r.frame_number;
            s_cost[best] <= f_cost; s_w[best] <= r.image_width; s_h[best] <= r.image_height;
            s_life[best] <= f_life; s_ret[best] <= f_ret;
            o_status <= ST_FILLED;
          end
        end
      end
      if (cmd.rb_scan && c_ret) begin
        rb_count <= rb_count + 1'b1;
        rb_bytes <= rb_bytes + {10'b0, c_pix, 2'b0};
        if (idx != vic && (!weak_ok || c_life < s_life[weak_idx])) begin
          weak_idx <= idx; weak_ok <= 1'b1;
        end
      end
      if (cmd.rb_act) begin
        rb_count <= '0; rb_bytes <= '0; weak_ok <= 1'b0;
        if (!sts.rb_ok && !sts.rb_stop) begin
          s_ret[rb_tgt] <= 1'b0; s_life[rb_tgt] <= LIFE_FLOOR;
        end
      end
      if (cmd.pin) begin
        o_slot <= SW'(r.slot_index);
        if (pin_in) begin
          if (r.opcode == OP_PIN) begin
            if (pin_cur != 8'hFF) s_pins[pidx] <= pin_cur + 1'b1;
            o_ret <= s_ret[pidx]; o_life <= s_life[pidx];
          end else if (pin_cur == 8'd1 && s_pend[pidx]) begin
            // The last unpin of a slot marked for drop releases it.
            if (s_valid[pidx]) closed[pidx] <= 1'b1;
            s_pins[pidx] <= '0;
            s_valid[pidx] <= 1'b0; s_key[pidx] <= '0; s_color[pidx] <= '0;
            s_frame[pidx] <= '0; s_life[pidx] <= '0; s_cost[pidx] <= '0;
            s_w[pidx] <= '0; s_h[pidx] <= '0; s_ret[pidx] <= 1'b0;
            s_pend[pidx] <= 1'b0;
            o_ret <= 1'b0; o_life <= '0;
          end else begin
            if (pin_cur != 8'd0) s_pins[pidx] <= pin_cur - 1'b1;
            o_ret <= s_ret[pidx]; o_life <= s_life[pidx];
          end
        end
      end
      if (cmd.inval && !sts.empty && (r.all_entries || (c_valid && c_key == r.source_key))) begin
        if (c_pins != 8'd0) s_pend[idx] <= 1'b1;
        else begin
          if (c_valid) closed[idx] <= 1'b1;
          s_valid[idx] <= 1'b0; s_key[idx] <= '0; s_color[idx] <= '0;
          s_frame[idx] <= '0; s_life[idx] <= '0; s_cost[idx] <= '0;
          s_w[idx] <= '0; s_h[idx] <= '0; s_ret[idx] <= 1'b0; s_pend[idx] <= 1'b0;
        end
      end
      if (cmd.emit && o_status == ST_FILLED) begin
        o_ret <= s_ret[vic]; o_life <= s_life[vic];
      end
    end
  end

  // Filled results read the slot at emit time since rebalance may demote it.
  logic [15:0] closed16;
  always_comb begin
    closed16 = '0;
    for (int i = 0; i < ENTRIES && i < 16; i++) closed16[i] = closed[i];
  end

  logic [3:0] slot16;
  assign slot16 = o_slot[3:0];

  assign res.status = o_status;
  assign res.slot = slot16;
  assign res.closed_mask = closed16;
  assign res.now_retained = (o_status == ST_FILLED) ? s_ret[vic] : o_ret;
  assign res.slot_life = (o_status == ST_FILLED) ? s_life[vic] : o_life;
endmodule

/* rtl/core/aging_life_cache_replacement.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aging_life_cache_replacement: aging-life cache directory top level
// Fully associative directory with aging, victim choice and a retained lane.
// ----------------------------------------------------------------------------
// One request at a time, set by the single shared slot scan; n is the active
// slot count. An open ages all n slots, then scans them for a match; a hit
// ends the scan there. On a miss it runs one or two victim passes, a fill
// step and, after a good open, rebalance passes, one per demotion plus a
// final one. An open with no active slots skips straight to the result.
// Pin and unpin go through the pin state, and invalidate scans the active
// slots. Every request ends in the done state, whose emit is registered
// into done. The result appears for one cycle with done high and cannot be
// stalled; busy is already low in that cycle, so the next request can be
// taken at its end.
module aging_life_cache_replacement #(
  parameter int ENTRIES = alcr_pkg::ENTRIES_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  alcr_pkg::req_t  request,
  output logic            busy,
  output logic            done,
  output alcr_pkg::res_t  result,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [2:0]      cfg_index,
  input  logic [31:0]     cfg_data
);
  import alcr_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  alcr_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .opcode(op_t'(request.opcode)),
    .sts(sts), .busy(busy), .cmd(cmd)
  );

  alcr_dp #(.ENTRIES(ENTRIES)) u_dp (
    .clk(clk), .rst(rst), .req(request), .cmd(cmd),
    .cfg_valid(cfg_valid & cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .sts(sts), .done(done), .res(result)
  );
endmodule

/* rtl/core/alcr_check.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alcr_check: port-level checks
// Watches the request and result handshake of the directory.
// ----------------------------------------------------------------------------
module alcr_check (
  input logic           clk,
  input logic           rst,
  input logic           start,
  input logic           busy,
  input logic           done,
  input alcr_pkg::res_t result
);
  import alcr_pkg::*;

  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("busy still high with result");
  a_done_once: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe longer than one cycle");
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("request not taken");
  a_status: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.status <= ST_DONE)) else $error("bad status code");
endmodule

bind aging_life_cache_replacement alcr_check u_check (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done), .result(result)
);
